// ===== hdl/led_matrix_row_scanner_unit_assert.svh =====
// Assertion macros for the LED matrix row scanner.
// Included by the top level; no other dependencies.
`ifndef LED_MATRIX_ROW_SCANNER_UNIT_ASSERT_SVH
`define LED_MATRIX_ROW_SCANNER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define LMRS_ASSERT_SAME(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("%m: assertion failed");
`define LMRS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("%m: assertion failed");
`else
`define LMRS_ASSERT_SAME(label, clk, rst_n, cond, prop)
`define LMRS_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif

`endif

// ===== hdl/lmrs_pkg.sv =====
// Package for the LED matrix row scanner: command codes, state type and
// the fixed key/LED to row/column tables. No dependencies.
`timescale 1ns / 1ps

package lmrs_pkg;

    localparam int KEY_COUNT    = 18;
    localparam int LEDS_PER_KEY = 3;
    localparam int MAP_ROW_W    = 2;
    localparam int MAP_COL_W    = 4;
    localparam int DIVIDER_W    = 8;
    localparam logic [DIVIDER_W-1:0] DIVIDER_RESET = 8'd2;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_SET    = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_COMMIT = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LED  = 4'b0010,
        S_COPY = 4'b0100,
        S_SCAN = 4'b1000
    } state_t;

    typedef struct packed {
        logic                 ok;
        logic [MAP_ROW_W-1:0] row;
        logic [MAP_COL_W-1:0] col;
    } led_map_t;

    localparam logic [MAP_ROW_W-1:0] KEY_ROW_MAP [KEY_COUNT][LEDS_PER_KEY] = '{
        '{2'd2, 2'd1, 2'd3}, '{2'd1, 2'd1, 2'd1}, '{2'd2, 2'd2, 2'd2},
        '{2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd0}, '{2'd3, 2'd3, 2'd3},
        '{2'd2, 2'd2, 2'd2}, '{2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd0},
        '{2'd3, 2'd3, 2'd3}, '{2'd2, 2'd2, 2'd2}, '{2'd1, 2'd1, 2'd1},
        '{2'd3, 2'd3, 2'd3}, '{2'd3, 2'd3, 2'd3}, '{2'd1, 2'd1, 2'd1},
        '{2'd0, 2'd0, 2'd0}, '{2'd2, 2'd2, 2'd2}, '{2'd1, 2'd1, 2'd1}
    };

    localparam logic [MAP_COL_W-1:0] KEY_COL_MAP [KEY_COUNT][LEDS_PER_KEY] = '{
        '{4'd4,  4'd4, 4'd4},  '{4'd5,  4'd0, 4'd6},  '{4'd5,  4'd0, 4'd6},
        '{4'd13, 4'd4, 4'd14}, '{4'd5,  4'd0, 4'd6},  '{4'd5,  4'd0, 4'd6},
        '{4'd11, 4'd3, 4'd12}, '{4'd11, 4'd3, 4'd12}, '{4'd7,  4'd1, 4'd8},
        '{4'd7,  4'd1, 4'd8},  '{4'd7,  4'd1, 4'd8},  '{4'd7,  4'd1, 4'd8},
        '{4'd11, 4'd3, 4'd12}, '{4'd9,  4'd2, 4'd10}, '{4'd9,  4'd2, 4'd10},
        '{4'd9,  4'd2, 4'd10}, '{4'd9,  4'd2, 4'd10}, '{4'd11, 4'd3, 4'd12}
    };

    // Keys of 18 and above and LED number 3 map to nothing.
    function automatic led_map_t led_map(input logic [4:0] key, input logic [1:0] led);
        led_map_t m;
        begin
            m = '0;
            if (key < 5'(KEY_COUNT) && led < 2'(LEDS_PER_KEY))
            begin
                m.ok  = 1'b1;
                m.row = KEY_ROW_MAP[key][led];
                m.col = KEY_COL_MAP[key][led];
            end
            return m;
        end
    endfunction

endpackage

// ===== hdl/led_matrix_row_scanner_unit.sv =====
// LED matrix row scanner top level: working and shown row memories,
// prescaler and command sequencer. Depends on lmrs_pkg and the assertion header.
`timescale 1ns / 1ps
`include "led_matrix_row_scanner_unit_assert.svh"

// Usage:
// A request is taken at a rising edge where start is high and busy is low.
// command selects tick, set LED, clear LED or commit; key_index and led_index
// name the LED for set and clear, and unmapped pairs are ignored.
// Set and clear do a read-modify-write of one working row.
// Commit copies the working memory into the shown memory one row per cycle
// through the single read port.
// A tick that does not reach divider_reg leaves busy low. A refreshing tick
// reads one shown row; the result appears on active_row, direct_columns and
// shift_columns with result_valid high for exactly one cycle, the cycle after
// the request, and busy is high in that cycle. The receiver cannot stall.
// divider_reg is to be written over cfg_valid/cfg_ready/cfg_data only while idle;
// the block does not enforce this. cfg_ready is always high.
// Reset clears the prescaler, the row pointer and the per-row valid bits, so
// both buffers read as zero at once; there is no clearing pass.
module led_matrix_row_scanner_unit #(
    parameter int ROW_COUNT      = 6,
    parameter int COLUMN_COUNT   = 21,
    parameter int DIRECT_COLUMNS = 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     command,
    input  logic [4:0]                     key_index,
    input  logic [1:0]                     led_index,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lmrs_pkg::DIVIDER_W-1:0] cfg_data,
    output logic                           result_valid,
    output logic [2:0]                     active_row,
    output logic [4:0]                     direct_columns,
    output logic [15:0]                    shift_columns
);
    import lmrs_pkg::*;

    localparam int ROW_W = $clog2(ROW_COUNT);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROW_COUNT - 1);

    state_t                state_reg, state_next;
    logic [DIVIDER_W-1:0]  divider_reg;
    logic [DIVIDER_W-1:0]  tick_count_reg, tick_count_next;
    logic [ROW_W-1:0]      scan_row_reg, scan_row_next;
    logic [ROW_W-1:0]      out_row_reg, out_row_next;
    logic [ROW_W-1:0]      copy_idx_reg, copy_idx_next;
    logic [ROW_W-1:0]      led_row_reg, led_row_next;
    logic [MAP_COL_W-1:0]  led_col_reg, led_col_next;
    logic                  led_on_reg, led_on_next;

    // Row memories; the valid bits make never-written rows read as zero.
    logic [COLUMN_COUNT-1:0] work_mem  [ROW_COUNT];
    logic [COLUMN_COUNT-1:0] shown_mem [ROW_COUNT];
    logic [ROW_COUNT-1:0]    work_valid_reg, shown_valid_reg;
    logic [COLUMN_COUNT-1:0] work_rd_reg, shown_rd_reg;
    logic                    work_rd_ok_reg, shown_rd_ok_reg;

    logic                    work_re, shown_re, work_we, shown_we;
    logic [ROW_W-1:0]        work_raddr, shown_raddr, work_waddr, shown_waddr;
    logic [COLUMN_COUNT-1:0] work_wdata, work_data, shown_data, col_mask;

    led_map_t                map;
    logic                    map_ok;
    logic                    accept;
    logic [DIVIDER_W-1:0]    tick_inc;
    logic [63:0]             row_ext;
    logic [ROW_W+2:0]        row_out_ext;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign map    = led_map(key_index, led_index);
    assign map_ok = map.ok && (32'(map.row) < ROW_COUNT) && (32'(map.col) < COLUMN_COUNT);

    assign tick_inc   = tick_count_reg + 1'b1;
    assign work_data  = work_rd_ok_reg ? work_rd_reg : '0;
    assign shown_data = shown_rd_ok_reg ? shown_rd_reg : '0;

    always_comb
    begin
        for (int i = 0; i < COLUMN_COUNT; i++)
        begin
            col_mask[i] = (32'(led_col_reg) == i);
        end
    end

    assign work_wdata = led_on_reg ? (work_data | col_mask) : (work_data & ~col_mask);

    always_comb
    begin
        state_next      = state_reg;
        tick_count_next = tick_count_reg;
        scan_row_next   = scan_row_reg;
        out_row_next    = out_row_reg;
        copy_idx_next   = copy_idx_reg;
        led_row_next    = led_row_reg;
        led_col_next    = led_col_reg;
        led_on_next     = led_on_reg;
        work_re         = 1'b0;
        work_raddr      = '0;
        shown_re        = 1'b0;
        shown_raddr     = scan_row_reg;
        work_we         = 1'b0;
        work_waddr      = led_row_reg;
        shown_we        = 1'b0;
        shown_waddr     = copy_idx_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_SET, CMD_CLEAR:
                        begin
                            if (map_ok)
                            begin
                                led_row_next = ROW_W'(map.row);
                                led_col_next = map.col;
                                led_on_next  = (command == CMD_SET);
                                work_re      = 1'b1;
                                work_raddr   = ROW_W'(map.row);
                                state_next   = S_LED;
                            end
                        end
                        CMD_COMMIT:
                        begin
                            copy_idx_next = '0;
                            work_re       = 1'b1;
                            work_raddr    = '0;
                            state_next    = S_COPY;
                        end
                        default:
                        begin
                            if (tick_inc < divider_reg)
                            begin
                                tick_count_next = tick_inc;
                            end
                            else
                            begin
                                tick_count_next = '0;
                                out_row_next    = scan_row_reg;
                                shown_re        = 1'b1;
                                shown_raddr     = scan_row_reg;
                                scan_row_next   = (scan_row_reg == LAST_ROW) ? '0
                                                : ROW_W'(scan_row_reg + 1'b1);
                                state_next      = S_SCAN;
                            end
                        end
                    endcase
                end
            end
            S_LED:
            begin
                work_we    = 1'b1;
                state_next = S_IDLE;
            end
            S_COPY:
            begin
                shown_we = 1'b1;
                if (copy_idx_reg == LAST_ROW)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    copy_idx_next = ROW_W'(copy_idx_reg + 1'b1);
                    work_re       = 1'b1;
                    work_raddr    = ROW_W'(copy_idx_reg + 1'b1);
                end
            end
            S_SCAN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            divider_reg     <= DIVIDER_RESET;
            tick_count_reg  <= '0;
            scan_row_reg    <= '0;
            copy_idx_reg    <= '0;
            work_valid_reg  <= '0;
            shown_valid_reg <= '0;
            work_rd_ok_reg  <= 1'b0;
            shown_rd_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_count_reg <= tick_count_next;
            scan_row_reg   <= scan_row_next;
            copy_idx_reg   <= copy_idx_next;
            if (cfg_valid && cfg_ready)
            begin
                divider_reg <= cfg_data;
            end
            if (work_we)
            begin
                work_valid_reg[work_waddr] <= 1'b1;
            end
            if (shown_we)
            begin
                shown_valid_reg[shown_waddr] <= work_rd_ok_reg;
            end
            if (work_re)
            begin
                work_rd_ok_reg <= work_valid_reg[work_raddr];
            end
            if (shown_re)
            begin
                shown_rd_ok_reg <= shown_valid_reg[shown_raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_row_reg <= out_row_next;
        led_row_reg <= led_row_next;
        led_col_reg <= led_col_next;
        led_on_reg  <= led_on_next;
    end

    // Synchronous memories with a registered read.
    always_ff @(posedge clk)
    begin
        if (work_we)
        begin
            work_mem[work_waddr] <= work_wdata;
        end
        if (work_re)
        begin
            work_rd_reg <= work_mem[work_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (shown_we)
        begin
            shown_mem[shown_waddr] <= work_data;
        end
        if (shown_re)
        begin
            shown_rd_reg <= shown_mem[shown_raddr];
        end
    end

    assign row_ext      = 64'(shown_data);
    assign row_out_ext  = (ROW_W + 3)'(out_row_reg);
    assign result_valid = (state_reg == S_SCAN);
    assign active_row   = row_out_ext[2:0];
    assign shift_columns = 16'(row_ext >> DIRECT_COLUMNS);

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            direct_columns[i] = (i < DIRECT_COLUMNS) ? row_ext[i] : 1'b0;
        end
    end

    `LMRS_ASSERT_NEXT(a_single_strobe, clk, rst_n, result_valid, !result_valid)
    `LMRS_ASSERT_NEXT(a_no_result_non_tick, clk, rst_n, accept && (command != CMD_TICK), !result_valid)
    `LMRS_ASSERT_NEXT(a_copy_ends, clk, rst_n, (state_reg == S_COPY) && (copy_idx_reg == LAST_ROW), state_reg == S_IDLE)
    `LMRS_ASSERT_SAME(a_refresh_row_range, clk, rst_n, result_valid, 32'(out_row_reg) < ROW_COUNT)

endmodule
